// ----- hw/rtl/swpr_pkg.sv -----
// Shared types and constants for the steering wheel position regulator.
// No dependencies; every other file of the block imports this package.
package swpr_pkg;

  // Encoder geometry: one revolution is 1024 counts.
  localparam int unsigned ENC_BITS = 10;

  // Fixed-point constants.
  localparam logic [26:0] INV_16PI_Q32 = 27'd85445659;  // round(2^28/pi)
  localparam logic [9:0]  WIN_LO       = 10'd512;        // index window start
  localparam logic [9:0]  WIN_HI       = 10'd768;        // index window end
  localparam logic [8:0]  HALF_CLAMP   = 9'd510;         // |error| clamp, half counts
  localparam logic [15:0] MAG_MAX      = 16'hFFFF;

  // Register reset values.
  localparam logic [23:0] VEL_SCALE_RST = 24'd3790385;
  localparam logic [9:0]  MOUNT_RST     = 10'd290;

  // Register indexes of the configuration port.
  localparam logic REG_VEL_SCALE = 1'b0;
  localparam logic REG_MOUNT     = 1'b1;

  // Input commands.
  typedef enum logic [2:0] {
    CMD_SETPOINT = 3'd0,
    CMD_ENCODER  = 3'd1,
    CMD_INDEX    = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_DRIVE    = 3'd4
  } cmd_e_t;

  // Frame kinds.
  typedef enum logic [1:0] {
    FK_POWER_ON  = 2'd0,
    FK_SET_SPEED = 2'd1,
    FK_TURN      = 2'd2
  } frame_kind_t;

  // Motors.
  localparam logic MOTOR_DRIVE = 1'b0;
  localparam logic MOTOR_STEER = 1'b1;

  // Frame lengths in bytes.
  localparam logic [2:0] LEN_POWER_ON  = 3'd1;
  localparam logic [2:0] LEN_SET_SPEED = 3'd4;
  localparam logic [2:0] LEN_TURN      = 3'd3;

  // Job queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queued job: a tick (angle and position snapshot) or a drive speed.
  typedef struct packed {
    logic        is_drive;
    logic [15:0] operand;
    logic [9:0]  pos;
  } job_t;

  // Back-end sequencer steps.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_RED,
    BK_EMIT
  } back_state_t;

endpackage

// ----- hw/rtl/swpr_front.sv -----
// Front end: accepts events, keeps configuration and controller state,
// and queues tick and drive jobs. Depends on swpr_pkg.
module swpr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          command,
  input  logic [15:0]         steer_angle,
  input  logic [9:0]          ticks,
  input  logic [15:0]         drive_speed,
  input  logic                q_full,
  output logic                q_push,
  output swpr_pkg::job_t      q_job,
  output logic [23:0]         velocity_scale
);
  import swpr_pkg::*;

  logic [15:0] setpoint_angle;
  logic [9:0]  encoder_position;
  logic [9:0]  index_offset;
  logic [9:0]  mount_offset;
  logic        accept;
  logic [9:0]  win_lo;
  logic [9:0]  win_hi;
  logic        in_window;
  logic [9:0]  pos;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Index window and steering position, both modulo one revolution
  assign win_lo    = WIN_LO - index_offset;
  assign win_hi    = WIN_HI - index_offset;
  assign in_window = (ticks >= win_lo) && (ticks <= win_hi);
  assign pos       = encoder_position + mount_offset - index_offset;

  // Classify the item and build a job for the back end
  always_comb begin
    q_push = 1'b0;
    q_job  = '{is_drive: 1'b0, operand: steer_angle, pos: pos};
    unique case (command)
      CMD_TICK: begin
        q_push = accept;
        q_job  = '{is_drive: 1'b0, operand: setpoint_angle, pos: pos};
      end
      CMD_DRIVE: begin
        q_push = accept;
        q_job  = '{is_drive: 1'b1, operand: drive_speed, pos: pos};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Update controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_angle   <= '0;
      encoder_position <= '0;
      index_offset     <= '0;
    end else if (accept) begin
      unique case (command)
        CMD_SETPOINT: setpoint_angle <= steer_angle;
        CMD_ENCODER:  encoder_position <= ticks;
        CMD_INDEX: begin
          if (in_window) begin
            index_offset <= ticks;
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_scale <= VEL_SCALE_RST;
      mount_offset   <= MOUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VEL_SCALE: velocity_scale <= cfg_data;
        REG_MOUNT:     mount_offset <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/swpr_queue.sv -----
// Short job queue between the front and back ends.
// Depends on swpr_pkg for the job type and depth.
module swpr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swpr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output swpr_pkg::job_t head
);
  import swpr_pkg::*;

  job_t                 slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/swpr_back.sv -----
// Back end: multiplies, reduces and frames tick and drive jobs into an
// output register. Depends on swpr_pkg.
module swpr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  swpr_pkg::job_t q_head,
  output logic           q_pop,
  input  logic [23:0]    velocity_scale,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           target_motor,
  output logic [1:0]     frame_kind,
  output logic           direction,
  output logic [15:0]    value,
  output logic [2:0]     byte_count,
  output logic           last
);
  import swpr_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  job_t               job;
  logic signed [43:0] prod;
  logic signed [43:0] prod_next;
  logic signed [24:0] red;
  logic signed [24:0] red_next;

  logic               out_free;
  logic               emit;
  logic               f_motor;
  frame_kind_t        f_kind;
  logic               f_dir;
  logic [15:0]        f_value;
  logic [2:0]         f_len;
  logic               f_last;

  logic signed [15:0] op_s;
  logic signed [27:0] coef_s;
  logic signed [11:0] sp_floor;
  logic signed [11:0] sp_trunc;
  logic signed [39:0] q_sum;
  logic signed [23:0] v_floor;
  logic signed [23:0] v_trunc;

  logic [24:0]        mag;
  logic [15:0]        mag_sat;
  logic signed [12:0] diff;
  logic [11:0]        habs;
  logic [8:0]         h;
  logic [7:0]         c_up;
  logic [9:0]         turn_val;

  assign out_free = !out_valid || out_ready;

  // Multiply: angle by 2^28/pi, or speed by velocity scale
  assign op_s      = $signed(job.operand);
  assign coef_s    = job.is_drive ? $signed({4'b0, velocity_scale})
                                  : $signed({1'b0, INV_16PI_Q32});
  assign prod_next = op_s * coef_s;

  // Reduce: truncate toward zero after the fixed-point shift
  assign sp_floor = $signed(prod[43:32]) + 12'sd256;
  assign sp_trunc = (sp_floor[11] && (prod[31:0] != '0)) ? sp_floor + 12'sd1 : sp_floor;
  assign q_sum    = $signed(prod[39:0]) + 40'sd32768;
  assign v_floor  = $signed(q_sum[39:16]);
  assign v_trunc  = (q_sum[39] && (q_sum[15:0] != '0)) ? v_floor + 24'sd1 : v_floor;
  assign red_next = job.is_drive ? 25'(v_trunc) : 25'(sp_trunc);

  // Speed magnitude, saturated
  assign mag     = red[24] ? 25'(-red) : red;
  assign mag_sat = (mag > 25'(MAG_MAX)) ? MAG_MAX : mag[15:0];

  // Turn value from position error in half counts
  assign diff     = $signed(red[12:0]) - $signed({3'b0, job.pos});
  assign habs     = diff[12] ? 12'(-diff) : diff[11:0];
  assign h        = (habs > 12'(HALF_CLAMP)) ? HALF_CLAMP : habs[8:0];
  assign c_up     = 8'(({1'b0, h} + 10'd1) >> 1);
  assign turn_val = (!diff[12] && (diff != '0)) ? 10'(h[8:1]) : 10'd0 - 10'(c_up);

  // Sequence steps, emit frames, pop the next job
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    q_pop      = 1'b0;
    f_motor    = MOTOR_DRIVE;
    f_kind     = FK_POWER_ON;
    f_dir      = 1'b0;
    f_value    = '0;
    f_len      = LEN_POWER_ON;
    f_last     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_not_empty;
        if (q_not_empty) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        if (job.is_drive) begin
          state_next = BK_RED;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = BK_RED;
        end
      end
      BK_RED: begin
        f_motor = MOTOR_STEER;
        if (job.is_drive) begin
          state_next = BK_EMIT;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        f_last = 1'b1;
        if (job.is_drive) begin
          f_motor = MOTOR_DRIVE;
          f_kind  = FK_SET_SPEED;
          f_dir   = red[24];
          f_value = mag_sat;
          f_len   = LEN_SET_SPEED;
        end else begin
          f_motor = MOTOR_STEER;
          f_kind  = FK_TURN;
          f_value = 16'(turn_val);
          f_len   = LEN_TURN;
        end
        if (out_free) begin
          emit       = 1'b1;
          q_pop      = q_not_empty;
          state_next = q_not_empty ? BK_MUL : BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the working job and intermediate results
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
    if (state == BK_MUL) begin
      prod <= prod_next;
    end
    if (state == BK_RED) begin
      red <= red_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      target_motor <= f_motor;
      frame_kind   <= f_kind;
      direction    <= f_dir;
      value        <= f_value;
      byte_count   <= f_len;
      last         <= f_last;
    end
  end

endmodule

// ----- hw/rtl/steering_wheel_position_regulator_top.sv -----
// Steering wheel position regulator: setpoint, encoder and index events
// update state when accepted; a tick gives three frames, a drive one.
// The back end multiplies, reduces and frames one job at a time, waiting
// while the output register is held; the queue takes new items meanwhile
// until it is full, and in_ready is low while it is full.
// Reset (synchronous) zeroes the state, empties the queue and restores config.
module steering_wheel_position_regulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [15:0] steer_angle,
  input  logic [9:0]  ticks,
  input  logic [15:0] drive_speed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        target_motor,
  output logic [1:0]  frame_kind,
  output logic        direction,
  output logic [15:0] value,
  output logic [2:0]  byte_count,
  output logic        last
);
  import swpr_pkg::*;

  logic        q_full;
  logic        q_push;
  job_t        q_job;
  logic        q_pop;
  logic        q_not_empty;
  job_t        q_head;
  logic [23:0] velocity_scale;

  swpr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .steer_angle    (steer_angle),
    .ticks          (ticks),
    .drive_speed    (drive_speed),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job),
    .velocity_scale (velocity_scale)
  );

  swpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  swpr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .velocity_scale (velocity_scale),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .target_motor   (target_motor),
    .frame_kind     (frame_kind),
    .direction      (direction),
    .value          (value),
    .byte_count     (byte_count),
    .last           (last)
  );

endmodule

// ----- tb/steering_wheel_position_regulator_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for steering_wheel_position_regulator_top: directed and
// random events, a frame predictor with its own state, and a check of every frame.
// Depends on swpr_pkg and the regulator RTL only.
module steering_wheel_position_regulator_top_test;
  import swpr_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
  // Offsets in this range give an index window that wraps and never accepts
  localparam logic [9:0] WRAP_FIRST = 10'd513;
  localparam logic [9:0] WRAP_LAST  = 10'd768;
  localparam logic [9:0] PARK_COUNT = 10'd600;

  typedef struct packed {
    logic        motor;
    logic [1:0]  kind;
    logic        dir;
    logic [15:0] val;
    logic [2:0]  len;
    logic        fin;
  } motor_frame_t;

  // Predicts the motor frames of each event and checks the frames that come out
  class regulator_model;
    localparam longint COUNTS         = 1024;
    localparam longint RECIP_16PI_Q32 = 85445659;
    localparam longint HALF_ERR_MAX   = 510;
    localparam longint MAG_LIMIT      = 65535;
    localparam logic   DIR_BACK       = 1'b0;
    localparam logic   DIR_FWD        = 1'b1;
    localparam int     REPORT_LIMIT   = 10;

    logic [23:0]  vel_scale;
    logic [9:0]   mount;
    logic [15:0]  angle;
    logic [9:0]   enc_pos;
    logic [9:0]   offset;
    motor_frame_t awaited[$];
    int events, tick_events, drive_events, checked, mismatches;

    function new();
      vel_scale = VEL_SCALE_RST;
      mount     = MOUNT_RST;
      angle     = '0;
      enc_pos   = '0;
      offset    = '0;
      events = 0; tick_events = 0; drive_events = 0; checked = 0; mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [23:0] data);
      if (idx == REG_VEL_SCALE) vel_scale = data;
      else mount = data[9:0];
    endfunction

    // Index window of 512..768 counts less the offset; empty when it wraps
    function bit in_window(logic [9:0] cnt);
      longint lo, hi;
      lo = (COUNTS - longint'(offset) + 512) % COUNTS;
      hi = (COUNTS - longint'(offset) + 768) % COUNTS;
      return longint'(cnt) >= lo && longint'(cnt) <= hi;
    endfunction

    function longint trunc_q32(longint x, int sh);
      if (x >= 0) return x >>> sh;
      return -((-x) >>> sh);
    endfunction

    // Proportional correction toward the setpoint, as a turn value
    function logic [15:0] turn_value();
      longint a, sp, pos, h;
      a   = longint'($signed(angle));
      sp  = trunc_q32(a * RECIP_16PI_Q32 + (longint'(256) << 32), 32) % COUNTS;
      pos = (COUNTS - longint'(offset) + longint'(enc_pos) + longint'(mount)) % COUNTS;
      h   = sp - pos;
      if (h < 0) h = -h;
      if (h > HALF_ERR_MAX) h = HALF_ERR_MAX;
      if (sp > pos) return 16'(h >> 1);
      return 16'((COUNTS - ((h + 1) >> 1)) % COUNTS);
    endfunction

    function motor_frame_t make_frame(logic motor, logic [1:0] kind, logic dir,
                                      logic [15:0] val, logic [2:0] len, logic fin);
      motor_frame_t f;
      f = '{motor, kind, dir, val, len, fin};
      return f;
    endfunction

    // Negated, scaled and rounded drive speed as direction and magnitude
    function motor_frame_t speed_frame(logic [15:0] spd);
      longint q, rpm, mag;
      logic   dir;
      q   = longint'($signed(spd)) * longint'(vel_scale) + 32768;
      rpm = -trunc_q32(q, 16);
      if (rpm > 0) begin
        dir = DIR_FWD;
        mag = rpm;
      end else begin
        dir = DIR_BACK;
        mag = -rpm;
      end
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      return make_frame(MOTOR_DRIVE, FK_SET_SPEED, dir, 16'(mag), LEN_SET_SPEED, 1'b1);
    endfunction

    function void take_event(logic [2:0] cmd, logic [15:0] ang, logic [9:0] cnt,
                             logic [15:0] spd);
      events++;
      case (cmd)
        CMD_SETPOINT: angle = ang;
        CMD_ENCODER:  enc_pos = cnt;
        CMD_INDEX:    if (in_window(cnt)) offset = cnt;
        CMD_TICK: begin
          tick_events++;
          awaited.push_back(make_frame(MOTOR_DRIVE, FK_POWER_ON, DIR_BACK, 16'd0,
                                       LEN_POWER_ON, 1'b0));
          awaited.push_back(make_frame(MOTOR_STEER, FK_POWER_ON, DIR_BACK, 16'd0,
                                       LEN_POWER_ON, 1'b0));
          awaited.push_back(make_frame(MOTOR_STEER, FK_TURN, DIR_BACK, turn_value(),
                                       LEN_TURN, 1'b1));
        end
        CMD_DRIVE: begin
          drive_events++;
          awaited.push_back(speed_frame(spd));
        end
        default: ;
      endcase
    endfunction

    function string show(motor_frame_t f);
      return $sformatf("motor=%0d kind=%0d dir=%0d value=%0d bytes=%0d last=%0d",
                       f.motor, f.kind, f.dir, f.val, f.len, f.fin);
    endfunction

    function void check_frame(motor_frame_t got);
      motor_frame_t want;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("frame with none awaited: %s", show(got));
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("frame mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [23:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  command     = '0;
  logic [15:0] steer_angle = '0;
  logic [9:0]  ticks       = '0;
  logic [15:0] drive_speed = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        target_motor;
  logic [1:0]  frame_kind;
  logic        direction;
  logic [15:0] value;
  logic [2:0]  byte_count;
  logic        last;

  regulator_model frames = new();
  bit calm = 1'b0;
  int settings = 1;

  steering_wheel_position_regulator_top DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .steer_angle(steer_angle), .ticks(ticks), .drive_speed(drive_speed),
    .out_valid(out_valid), .out_ready(out_ready),
    .target_motor(target_motor), .frame_kind(frame_kind), .direction(direction),
    .value(value), .byte_count(byte_count), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Check each frame taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      frames.check_frame({target_motor, frame_kind, direction, value, byte_count, last});
  end

  // Stall the receiver in random bursts, none once the run is calm
  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Present one item, hold it until taken, then maybe idle for a burst
  task automatic send_event(logic [2:0] cmd, logic [15:0] ang, logic [9:0] cnt,
                            logic [15:0] spd);
    in_valid    <= 1'b1;
    command     <= cmd;
    steer_angle <= ang;
    ticks       <= cnt;
    drive_speed <= spd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames.take_event(cmd, ang, cnt, spd);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Hold the sender until every awaited frame is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (frames.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [23:0] scale, logic [9:0] mnt);
    cfg_write <= 1'b1;
    cfg_index <= REG_VEL_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    frames.set_register(REG_VEL_SCALE, scale);
    cfg_index <= REG_MOUNT;
    cfg_data  <= {14'($urandom), mnt};
    @(posedge clk);
    frames.set_register(REG_MOUNT, {14'd0, mnt});
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Edge count mostly inside the current window; keep out of the wrapping
  // offsets unless allowed
  function automatic logic [9:0] pick_edge_count(bit wrap_ok);
    logic [9:0] cnt;
    do begin
      if ($urandom_range(0, 2) != 0)
        cnt = 10'(512 - int'(frames.offset) + int'($urandom_range(0, 256)));
      else
        cnt = 10'($urandom);
    end while (!wrap_ok && frames.in_window(cnt) && cnt >= WRAP_FIRST && cnt <= WRAP_LAST);
    return cnt;
  endfunction

  task automatic random_events(int count, bit wrap_ok);
    int          pick;
    logic [2:0]  cmd;
    logic [15:0] spd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)      cmd = CMD_SETPOINT;
      else if (pick < 33) cmd = CMD_ENCODER;
      else if (pick < 43) cmd = CMD_INDEX;
      else if (pick < 73) cmd = CMD_TICK;
      else if (pick < 95) cmd = CMD_DRIVE;
      else                cmd = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
      if ($urandom_range(0, 1)) spd = 16'($urandom);
      else spd = 16'(int'($urandom_range(0, 1023)) - 512);
      send_event(cmd, 16'($urandom),
                 (cmd == CMD_INDEX) ? pick_edge_count(wrap_ok) : 10'($urandom), spd);
    end
  endtask

  task automatic directed_events();
    // Tick from reset state, then at both angle extremes
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
    send_event(CMD_SETPOINT, 16'h8000, 10'd0,    16'h0000);
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
    send_event(CMD_SETPOINT, 16'h7FFF, 10'd0,    16'h0000);
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
    send_event(CMD_ENCODER,  16'h0000, 10'd1023, 16'h0000);
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
    // Index edges just outside, at and below the window bounds
    send_event(CMD_INDEX,    16'h0000, 10'd1023, 16'h0000);
    send_event(CMD_INDEX,    16'h0000, 10'd511,  16'h0000);
    send_event(CMD_INDEX,    16'h0000, 10'd512,  16'h0000);
    send_event(CMD_INDEX,    16'h0000, 10'd0,    16'h0000);
    send_event(CMD_INDEX,    16'h0000, 10'd200,  16'h0000);
    send_event(CMD_ENCODER,  16'h0000, 10'd0,    16'h0000);
    send_event(CMD_SETPOINT, 16'hC000, 10'd0,    16'h0000);
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
    // Drive speeds: zero, saturating both ways, smallest steps
    send_event(CMD_DRIVE,    16'h0000, 10'd0,    16'h0000);
    send_event(CMD_DRIVE,    16'h0000, 10'd0,    16'h7FFF);
    send_event(CMD_DRIVE,    16'h0000, 10'd0,    16'h8000);
    send_event(CMD_DRIVE,    16'h0000, 10'd0,    16'h0001);
    send_event(CMD_DRIVE,    16'h0000, 10'd0,    16'hFFFF);
    // Unknown commands must do nothing
    send_event(CMD_BAD_FIRST, 16'hFFFF, 10'd1023, 16'hFFFF);
    send_event(CMD_BAD_LAST,  16'h8000, 10'd512,  16'h8000);
    send_event(CMD_TICK,     16'h0000, 10'd0,    16'h0000);
  endtask

  // Walk the offset until the parking count is in window, then park it where
  // the window wraps so later edges are dropped
  task automatic enter_wrapped_window();
    int tries;
    tries = 0;
    while (!frames.in_window(PARK_COUNT) && tries < 40) begin
      send_event(CMD_INDEX, 16'($urandom), pick_edge_count(1'b0), 16'($urandom));
      tries++;
    end
    send_event(CMD_INDEX, 16'($urandom), PARK_COUNT, 16'($urandom));
    send_event(CMD_INDEX, 16'($urandom), 10'd1023, 16'($urandom));
    send_event(CMD_INDEX, 16'($urandom), 10'd0, 16'($urandom));
    send_event(CMD_TICK, 16'($urandom), 10'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings
    directed_events();
    random_events(60, 1'b0);
    drain();

    // Both registers at zero; hold the sender midway until all frames are out
    write_settings(24'd0, 10'd0);
    random_events(30, 1'b0);
    drain();
    random_events(30, 1'b0);
    drain();

    // Both registers at full scale
    write_settings(24'hFFFFFF, 10'd1023);
    random_events(60, 1'b0);
    drain();

    write_settings(24'($urandom), 10'($urandom));
    random_events(50, 1'b0);
    drain();

    // Last part: no idling on either side, offset parked in a wrapping window
    calm = 1'b1;
    write_settings(24'd1, 10'($urandom));
    enter_wrapped_window();
    random_events(50, 1'b1);
    drain();

    $display("Covered %0d events (%0d ticks, %0d drive commands) over %0d register settings",
             frames.events, frames.tick_events, frames.drive_events, settings);
    $display("Checked %0d frames, %0d mismatches", frames.checked, frames.mismatches);
    if (frames.mismatches == 0 && frames.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
